// File: rtl/aes_pkg.sv
package aes_pkg;

	localparam int ROUNDS = 10;
	localparam int NKEYS = 2 * (ROUNDS + 1);
	localparam int RK_W = 128;
	localparam int RIDX_W = $clog2(ROUNDS + 1);

	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW = 1'b1;

	typedef logic [127:0] block_t;
	typedef block_t rk_arr_t [ROUNDS + 1];

	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] r;
		unique case (a)
			8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
			8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
			8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
			8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
			8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
			8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
			8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
			8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
			8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
			8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
			8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
			8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
			8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
			8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
			8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
			8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
			8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
			8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
			8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
			8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
			8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
			8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
			8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
			8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
			8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
			8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
			8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
			8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
			8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
			8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
			8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
			8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
			8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
			8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
			8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
			8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
			8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
			8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
			8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
			8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
			8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
			8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
			8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
			8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
			8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
			8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
			8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
			8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
			8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
			8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
			8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
			8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
			8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
			8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
			8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
			8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
			8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
			8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
			8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
			8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
			8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
			8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
			8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
			8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] rcon(input logic [RIDX_W-1:0] i);
		logic [7:0] r;
		unique case (i)
			4'd0: r = 8'h01; 4'd1: r = 8'h02; 4'd2: r = 8'h04; 4'd3: r = 8'h08;
			4'd4: r = 8'h10; 4'd5: r = 8'h20; 4'd6: r = 8'h40; 4'd7: r = 8'h80;
			4'd8: r = 8'h1b; 4'd9: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// byte 0 sits in bits 127:120
	function automatic logic [7:0] get_byte(input block_t s, input int i);
		return s[127 - 8*i -: 8];
	endfunction

	function automatic block_t sub_shift(input block_t s);
		block_t t;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[127 - 8*(r + 4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) & 3)));
		return t;
	endfunction

	function automatic block_t mix_columns(input block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c + 1);
			a2 = get_byte(s, 4*c + 2);
			a3 = get_byte(s, 4*c + 3);
			al = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 8*(4*c) -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			t[127 - 8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			t[127 - 8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			t[127 - 8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

	function automatic logic [31:0] sub_rot(input logic [31:0] w);
		return {sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
	endfunction

endpackage

// File: rtl/aes_key_sched.sv
module aes_key_sched (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [0:0]           cfg_sel,
	input  logic [63:0]          cfg_data,
	output aes_pkg::rk_arr_t     rk,
	output logic                 busy
);
	import aes_pkg::*;

	// one round key per cycle after each key write
	logic [63:0]       key_hi_q, key_lo_q;
	block_t            rk_q [ROUNDS + 1];
	logic [RIDX_W-1:0] idx_q;
	logic              run_q;
	logic              init_q;
	block_t            prev, nxt;
	logic [31:0]       t;

	always_comb begin
		prev = rk_q[idx_q];
		t = sub_rot(prev[31:0]) ^ {rcon(idx_q), 24'h0};
		nxt[127:96] = prev[127:96] ^ t;
		nxt[95:64] = prev[95:64] ^ nxt[127:96];
		nxt[63:32] = prev[63:32] ^ nxt[95:64];
		nxt[31:0] = prev[31:0] ^ nxt[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			run_q <= 1'b1;
			init_q <= 1'b1;
			idx_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_sel == REG_KEY_HIGH) key_hi_q <= cfg_data;
				else key_lo_q <= cfg_data;
				init_q <= 1'b1;
				run_q <= 1'b1;
				idx_q <= '0;
			end else if (init_q) begin
				init_q <= 1'b0;
			end else if (run_q) begin
				if (idx_q == RIDX_W'(ROUNDS - 1)) run_q <= 1'b0;
				else idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (init_q && !cfg_we) rk_q[0] <= {key_hi_q, key_lo_q};
		else if (run_q && !init_q && !cfg_we) rk_q[idx_q + 1'b1] <= nxt;
	end

	always_comb
		for (int i = 0; i <= ROUNDS; i++) rk[i] = rk_q[i];

	assign busy = run_q;
endmodule

// File: rtl/aes_round.sv
module aes_round (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           mix,
	input  aes_pkg::ctl_t  ctl_i,
	input  aes_pkg::block_t st_i,
	input  aes_pkg::block_t rk_i,
	output aes_pkg::ctl_t  ctl_o,
	output aes_pkg::block_t st_o
);
	import aes_pkg::*;

	block_t ss, mc;
	ctl_t   ctl_s1;
	block_t st_s1;

	always_comb begin
		ss = sub_shift(st_i);
		mc = mix ? mix_columns(ss) : ss;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s1 <= '0;
		else if (adv) ctl_s1 <= ctl_i;
	end

	always_ff @(posedge clk)
		if (adv) st_s1 <= mc ^ rk_i;

	assign ctl_o = ctl_s1;
	assign st_o = st_s1;
endmodule

// File: rtl/aes128_block_encrypt_top.sv
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | plain_high, plain_low, final_block
// out     | out_valid | out_stall | cipher_high, cipher_low, last_out
// one beat per cycle while neither in_stall nor out_stall holds; a key add stage plus ten round stages
// each round stage holds one sbox/mixcolumns/key-add layer (the last skips mixcolumns), which sets the clock
// after reset and after each key write the schedule is rebuilt one round key at a time,
// and in_stall stays high meanwhile
// out_stall with a valid output beat freezes the whole pipeline; no beat is dropped
module aes128_block_encrypt_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	input  logic        final_block,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low,
	output logic        last_out,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import aes_pkg::*;

	rk_arr_t rk;
	logic    busy;
	logic    adv;
	ctl_t    ctl [ROUNDS + 1];
	block_t  st [ROUNDS + 1];
	ctl_t    ctl_s0;
	block_t  st_s0;

	aes_key_sched u_ks (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_sel(cfg_index),
		.cfg_data(cfg_data), .rk(rk), .busy(busy)
	);

	assign adv = !(ctl[ROUNDS].valid && out_stall);
	assign in_stall = busy || !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s0 <= '0;
		else if (adv) ctl_s0 <= '{valid: in_valid && !busy, last: final_block};
	end

	always_ff @(posedge clk)
		if (adv) st_s0 <= {plain_high, plain_low} ^ rk[0];

	assign ctl[0] = ctl_s0;
	assign st[0] = st_s0;

	for (genvar r = 1; r <= ROUNDS; r++) begin : g_rnd
		aes_round u_rnd (
			.clk(clk), .arst_n(arst_n), .adv(adv), .mix(r != ROUNDS),
			.ctl_i(ctl[r-1]), .st_i(st[r-1]), .rk_i(rk[r]),
			.ctl_o(ctl[r]), .st_o(st[r])
		);
	end

	assign out_valid = ctl[ROUNDS].valid;
	assign last_out = ctl[ROUNDS].last;
	assign cipher_high = st[ROUNDS][127:64];
	assign cipher_low = st[ROUNDS][63:0];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cipher_high) && $stable(last_out))
		else $error("output beat changed under stall");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("input taken during key expansion");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("key write did not start expansion");
endmodule

// File: tb/aes128_block_checker.sv
module aes128_block_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [63:0] plain_high,
	input  logic [63:0] plain_low,
	input  logic        final_block,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] cipher_high,
	input  logic [63:0] cipher_low,
	input  logic        last_out,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          n_fail,
	output int          n_pending
);
	import aes_pkg::*;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        last;
	} cipher_beat_t;

	cipher_beat_t cipher_q[$];
	logic [63:0]  key_hi_q;
	logic [63:0]  key_lo_q;

	function automatic logic [7:0] gf_double(input logic [7:0] b);
		return (b << 1) ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				p ^= a;
			a = gf_double(a);
		end
		return p;
	endfunction

	// multiplicative inverse as a^254, then the affine map
	function automatic logic [7:0] sub_byte(input logic [7:0] a);
		logic [7:0] inv, sq;
		inv = 8'h01;
		sq = a;
		for (int i = 0; i < 8; i++) begin
			if (i != 0)
				inv = gf_mul(inv, sq);
			sq = gf_mul(sq, sq);
		end
		return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
			^ {inv[3:0], inv[7:4]} ^ 8'h63;
	endfunction

	function automatic logic [127:0] encrypt_block(input logic [127:0] key,
			input logic [127:0] pt);
		logic [31:0]  w [44];
		logic [31:0]  t;
		logic [7:0]   rc;
		logic [127:0] st, nx;
		logic [7:0]   a0, a1, a2, a3, al;
		rc = 8'h01;
		for (int i = 0; i < 4; i++)
			w[i] = key[127 - 32*i -: 32];
		for (int i = 4; i < 44; i++) begin
			t = w[i-1];
			if (i % 4 == 0) begin
				t = {sub_byte(t[23:16]), sub_byte(t[15:8]), sub_byte(t[7:0]),
					sub_byte(t[31:24])} ^ {rc, 24'h0};
				rc = gf_double(rc);
			end
			w[i] = w[i-4] ^ t;
		end
		st = pt ^ {w[0], w[1], w[2], w[3]};
		for (int r = 1; r <= 10; r++) begin
			for (int c = 0; c < 4; c++)
				for (int b = 0; b < 4; b++)
					nx[127 - 8*(b + 4*c) -: 8] =
						sub_byte(st[127 - 8*(b + 4*((c + b) % 4)) -: 8]);
			st = nx;
			if (r != 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = st[127 - 32*c -: 8];
					a1 = st[119 - 32*c -: 8];
					a2 = st[111 - 32*c -: 8];
					a3 = st[103 - 32*c -: 8];
					al = a0 ^ a1 ^ a2 ^ a3;
					st[127 - 32*c -: 8] = a0 ^ al ^ gf_double(a0 ^ a1);
					st[119 - 32*c -: 8] = a1 ^ al ^ gf_double(a1 ^ a2);
					st[111 - 32*c -: 8] = a2 ^ al ^ gf_double(a2 ^ a3);
					st[103 - 32*c -: 8] = a3 ^ al ^ gf_double(a3 ^ a0);
				end
			end
			st ^= {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
		end
		return st;
	endfunction

	initial n_fail = 0;
	initial n_pending = 0;

	// sample at the falling edge: these values hold through the next rising edge
	always @(negedge clk or negedge arst_n) begin
		cipher_beat_t exp_beat;
		logic [127:0] ct;
		if (!arst_n) begin
			key_hi_q = '0;
			key_lo_q = '0;
			cipher_q.delete();
			n_pending = 0;
		end else if (clk == 1'b0) begin
			if (out_valid && !out_stall) begin
				if (cipher_q.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected cipher beat %h %h last %b", $realtime,
						cipher_high, cipher_low, last_out);
				end else begin
					exp_beat = cipher_q.pop_front();
					if (cipher_high !== exp_beat.hi) begin
						n_fail++;
						$display("%0t: cipher_high expected %h actual %h", $realtime,
							exp_beat.hi, cipher_high);
					end
					if (cipher_low !== exp_beat.lo) begin
						n_fail++;
						$display("%0t: cipher_low expected %h actual %h", $realtime,
							exp_beat.lo, cipher_low);
					end
					if (last_out !== exp_beat.last) begin
						n_fail++;
						$display("%0t: last_out expected %b actual %b", $realtime,
							exp_beat.last, last_out);
					end
				end
			end
			if (in_valid && !in_stall) begin
				ct = encrypt_block({key_hi_q, key_lo_q}, {plain_high, plain_low});
				exp_beat.hi = ct[127:64];
				exp_beat.lo = ct[63:0];
				exp_beat.last = final_block;
				cipher_q.push_back(exp_beat);
			end
			if (cfg_we) begin
				if (cfg_index == REG_KEY_HIGH)
					key_hi_q = cfg_data;
				else if (cfg_index == REG_KEY_LOW)
					key_lo_q = cfg_data;
			end
			n_pending = cipher_q.size();
		end
	end

endmodule

// File: tb/tb_aes128_block_encrypt_top.sv
module tb_aes128_block_encrypt_top;
	import aes_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam logic [63:0] ONES = '1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] plain_high = '0;
	logic [63:0] plain_low = '0;
	logic        final_block = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] cipher_high;
	logic [63:0] cipher_low;
	logic        last_out;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = REG_KEY_HIGH;
	logic [63:0] cfg_data = '0;

	int n_fail;
	int n_pending;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int idle_cycles = 0;
	int n_blocks = 0;
	int n_key_writes = 0;

	aes128_block_encrypt_top dut (.*);

	aes128_block_checker chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < rcv_stall_pct);

	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else if (++idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic fin);
		logic stalled;
		if ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		plain_high <= hi;
		plain_low <= lo;
		final_block <= fin;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		n_blocks++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (n_pending != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_key(input bit do_hi, input logic [63:0] hi,
			input bit do_lo, input logic [63:0] lo);
		if (do_hi) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_KEY_HIGH;
			cfg_data <= hi;
			@(posedge clk);
			n_key_writes++;
		end
		if (do_lo) begin
			cfg_we <= 1'b1;
			cfg_index <= REG_KEY_LOW;
			cfg_data <= lo;
			@(posedge clk);
			n_key_writes++;
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rand_half();
		case ($urandom_range(7))
			0: return '0;
			1: return ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin
		int phase;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset schedule belongs to the all-zero key
		send_block('0, '0, 1'b0);
		send_block(ONES, ONES, 1'b1);
		send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b0);
		drain();
		// half-written key: only the high half changes
		write_key(1'b1, 64'h0001_0203_0405_0607, 1'b0, '0);
		send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 1'b1);
		drain();
		write_key(1'b0, '0, 1'b1, 64'h0809_0a0b_0c0d_0e0f);
		send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff, 1'b0);
		send_block('0, ONES, 1'b1);
		send_block(ONES, '0, 1'b0);
		drain();
		write_key(1'b1, ONES, 1'b1, ONES);
		send_block('0, '0, 1'b1);
		send_block(ONES, ONES, 1'b0);
		send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
		drain();

		for (phase = 0; phase < 12; phase++) begin
			snd_idle_pct = (phase < 4) ? 22 : (phase < 8) ? 52 : 0;
			rcv_stall_pct = (phase < 4) ? 52 : (phase < 8) ? 22 : 0;
			if (phase == 0)
				write_key(1'b1, '0, 1'b1, '0);
			else if (phase == 1)
				write_key(1'b1, ONES, 1'b1, ONES);
			else if (phase % 3 == 2)
				write_key(1'b1, rand_half(), 1'b0, '0);
			else
				write_key(1'b1, rand_half(), 1'b1, rand_half());
			repeat (140) send_block(rand_half(), rand_half(), 1'($urandom_range(1)));
			drain();
		end

		$display("tb: %0d blocks encrypted under %0d key register writes", n_blocks,
			n_key_writes);
		$display("tb: sender and receiver pacing swept, including half-key updates");
		if (n_fail == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
